// ----- hw/rtl/pwl_pkg.sv -----
// Shared types and constants for the piecewise linear table interpolator.
// No dependencies; imported by the top level and by its port checker.
package pwl_pkg;

  // Table geometry
  localparam int MAX_POINTS = 64;
  localparam int PTS_AW     = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;

  // Data widths (signed Q16.16)
  localparam int DATA_W    = 32;
  localparam int QUO_W     = DATA_W + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Operation codes on the input beat
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Clamp codes on the result beat
  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_FIRST = 2'd1;
  localparam logic [1:0] CLAMP_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_PROD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/piecewise_linear_table_interpolator.sv -----
// Piecewise linear interpolation over a 64-entry breakpoint table.
// Depends on pwl_pkg (types, codes, widths).
//
//   channel | direction | signals                                   | handshake
//   input   | in        | func entry_index entry_x entry_y query_x  | in_valid / in_stall
//   result  | out       | value segment clamp                       | out_valid / out_stall
//   config  | in        | cfg_wr_data (point_count)                 | cfg_wr_en, no wait
//
// A write beat does not stall the input. A query scans one table entry per cycle out of the
// breakpoint memory until it hits or reaches the last entry, then, unless it clamps, interpolates:
// one 32x32 multiply, one correction add, a 33-step restoring divider and a final add.
// rst clears control state only; table contents are undefined until written.
// A finished result waits in the output register while further write beats are taken;
// a new query can finish behind it and then holds until the output register frees up.
module piecewise_linear_table_interpolator (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [pwl_pkg::CNT_W-1:0]  cfg_wr_data,
  // input beats
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [pwl_pkg::PTS_AW-1:0] entry_index,
  input  logic signed [31:0]         entry_x,
  input  logic signed [31:0]         entry_y,
  input  logic signed [31:0]         query_x,
  // result beats
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         value,
  output logic [pwl_pkg::PTS_AW-1:0] segment,
  output logic [1:0]                 clamp
);
  import pwl_pkg::*;

  state_t state, state_next;

  // breakpoint memory: {x, y} per entry, registered read
  logic [2*DATA_W-1:0] mem [MAX_POINTS];
  logic [2*DATA_W-1:0] mem_q;
  logic [PTS_AW-1:0]   rd_addr;

  logic [CNT_W-1:0]    point_count;

  // scan registers
  logic [PTS_AW-1:0]   data_idx;
  logic [PTS_AW-1:0]   last_idx;
  logic [DATA_W-1:0]   q_reg;
  logic [DATA_W-1:0]   prev_x;
  logic [DATA_W-1:0]   prev_y;

  // interpolation operands
  logic [DATA_W-1:0]   op_dq;
  logic [DATA_W-1:0]   op_dx;
  logic [QUO_W-1:0]    op_mag;
  logic                op_neg;
  logic [DATA_W-1:0]   op_ya;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   rem;
  logic [QUO_W-1:0]    sh;
  logic [STEP_W-1:0]   step;

  // pending result
  logic [DATA_W-1:0]   res_value;
  logic [PTS_AW-1:0]   res_seg;
  logic [1:0]          res_clamp;

  logic in_acc, wr_acc, qry_acc, load_out;
  logic scan_hit, scan_last;
  logic [DATA_W-1:0] cur_x, cur_y;
  logic [DATA_W:0]   dq_w, dx_w, dy_w, mag_w;
  logic [2*DATA_W-1:0] prod_w;
  logic [2*DATA_W:0]   dvd_w;
  logic [QUO_W-1:0]    trial;
  logic [QUO_W-1:0]    diff;
  logic                ge;
  logic [DATA_W+1:0]   sum_w;
  logic [DATA_W-1:0]   sat_w;
  logic [PTS_AW-1:0]   last_w;

  assign in_acc  = in_valid && !in_stall;
  assign wr_acc  = in_acc && (func == FUNC_WRITE);
  assign qry_acc = in_acc && (func == FUNC_QUERY);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  // last entry in use: a count of zero acts as one, large counts saturate
  always_comb begin
    if (point_count == '0) begin
      last_w = '0;
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      last_w = PTS_AW'(MAX_POINTS - 1);
    end else begin
      last_w = PTS_AW'(point_count - CNT_W'(1));
    end
  end

  // memory: one write port for write beats, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (wr_acc) begin
      mem[entry_index] <= {entry_x, entry_y};
    end
    mem_q <= mem[rd_addr];
  end

  // scan compare and interpolation operand prep
  assign cur_x     = mem_q[2*DATA_W-1:DATA_W];
  assign cur_y     = mem_q[DATA_W-1:0];
  assign scan_hit  = $signed(cur_x) >= $signed(q_reg);
  assign scan_last = (data_idx == last_idx);
  assign dq_w  = {q_reg[DATA_W-1], q_reg} - {prev_x[DATA_W-1], prev_x};
  assign dx_w  = {cur_x[DATA_W-1], cur_x} - {prev_x[DATA_W-1], prev_x};
  assign dy_w  = {cur_y[DATA_W-1], cur_y} - {prev_y[DATA_W-1], prev_y};
  assign mag_w = dy_w[DATA_W] ? (~dy_w + (DATA_W+1)'(1)) : dy_w;

  // product dq * |dy|; the top bit of |dy| is folded in by the correction add
  assign prod_w = op_dq * op_mag[DATA_W-1:0];
  assign dvd_w  = {1'b0, prod} + (op_mag[DATA_W] ? {1'b0, op_dq, {DATA_W{1'b0}}} : '0);

  // one restoring divide step
  assign trial = {rem, sh[QUO_W-1]};
  assign diff  = trial - {1'b0, op_dx};
  assign ge    = trial >= {1'b0, op_dx};

  // final add and saturation
  assign sum_w = op_neg ? ({{2{op_ya[DATA_W-1]}}, op_ya} - {1'b0, sh})
                        : ({{2{op_ya[DATA_W-1]}}, op_ya} + {1'b0, sh});
  always_comb begin
    if (sum_w[DATA_W+1] && !(sum_w[DATA_W] && sum_w[DATA_W-1])) begin
      sat_w = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!sum_w[DATA_W+1] && (sum_w[DATA_W] || sum_w[DATA_W-1])) begin
      sat_w = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_w = sum_w[DATA_W-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control outputs
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_addr    = '0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (qry_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = data_idx + PTS_AW'(1);
        if (scan_hit && data_idx == '0) begin
          state_next = ST_DONE;
        end else if (scan_hit) begin
          state_next = ST_MUL;
        end else if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_MUL:  state_next = ST_PROD;
      ST_PROD: state_next = ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q_reg    <= query_x;
        last_idx <= last_w;
        data_idx <= '0;
      end
      ST_SCAN: begin
        prev_x   <= cur_x;
        prev_y   <= cur_y;
        data_idx <= data_idx + PTS_AW'(1);
        op_dq    <= dq_w[DATA_W-1:0];
        op_dx    <= dx_w[DATA_W-1:0];
        op_mag   <= mag_w;
        op_neg   <= dy_w[DATA_W];
        op_ya    <= prev_y;
        res_seg  <= data_idx;
        if (scan_hit && data_idx == '0) begin
          res_value <= cur_y;
          res_clamp <= CLAMP_FIRST;
        end else if (scan_hit) begin
          res_clamp <= CLAMP_NONE;
        end else begin
          res_value <= cur_y;
          res_clamp <= CLAMP_LAST;
        end
      end
      ST_MUL: begin
        prod <= prod_w;
      end
      ST_PROD: begin
        rem  <= dvd_w[2*DATA_W:QUO_W];
        sh   <= dvd_w[QUO_W-1:0];
        step <= '0;
      end
      ST_DIV: begin
        rem  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        sh   <= {sh[QUO_W-2:0], ge};
        step <= step + STEP_W'(1);
      end
      ST_FIN: begin
        res_value <= sat_w;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value   <= res_value;
      segment <= res_seg;
      clamp   <= res_clamp;
    end
  end

endmodule

// ----- hw/rtl/pwl_checker.sv -----
// Port-level checks for the piecewise linear table interpolator, bound to the top level.
// Depends on pwl_pkg (codes and widths).
module pwl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       func,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [31:0]         value,
  input logic [pwl_pkg::PTS_AW-1:0] segment,
  input logic [1:0]                 clamp
);
  import pwl_pkg::*;

  // a held result beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(segment)
                               && $stable(clamp))
    else $error("result beat changed while stalled");

  // only the three defined clamp codes appear
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clamp == CLAMP_NONE) || (clamp == CLAMP_FIRST) || (clamp == CLAMP_LAST))
    else $error("undefined clamp code");

  // clamp to first entry always reports entry zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp == CLAMP_FIRST |-> segment == '0)
    else $error("first-entry clamp with nonzero segment");

  // a query occupies the block for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_QUERY |=> in_stall)
    else $error("input taken right after a query");

  // a write beat does not stall the input
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_WRITE |=> !in_stall)
    else $error("write beat stalled the input");

endmodule

bind piecewise_linear_table_interpolator pwl_checker u_pwl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .segment   (segment),
  .clamp     (clamp)
);
